>>> design/dmrc_pkg.sv
// ----------------------------------------------------------------------------
// dmrc_pkg
// shared types and codes of the door motor ramp controller
// ----------------------------------------------------------------------------
package dmrc_pkg;

    // register indexes of the configuration port
    localparam logic [2:0] REG_FAST_DUTY        = 3'd0;
    localparam logic [2:0] REG_SLOW_DUTY        = 3'd1;
    localparam logic [2:0] REG_MIN_DUTY         = 3'd2;
    localparam logic [2:0] REG_RAMP_INCREMENT   = 3'd3;
    localparam logic [2:0] REG_RAMP_INTERVAL_MS = 3'd4;
    localparam logic [2:0] REG_OPEN_TIMEOUT_MS  = 3'd5;
    localparam logic [2:0] REG_CLOSE_TIMEOUT_MS = 3'd6;
    localparam logic [2:0] REG_STALL_TIMEOUT_MS = 3'd7;

    // register reset values
    localparam logic [7:0]  RST_FAST_DUTY        = 8'd200;
    localparam logic [7:0]  RST_SLOW_DUTY        = 8'd80;
    localparam logic [7:0]  RST_MIN_DUTY         = 8'd30;
    localparam logic [7:0]  RST_RAMP_INCREMENT   = 8'd5;
    localparam logic [15:0] RST_RAMP_INTERVAL_MS = 16'd20;
    localparam logic [31:0] RST_OPEN_TIMEOUT_MS  = 32'd10000;
    localparam logic [31:0] RST_CLOSE_TIMEOUT_MS = 32'd10000;
    localparam logic [15:0] RST_STALL_TIMEOUT_MS = 16'd500;

    typedef enum logic [1:0] {
        OP_POLL  = 2'd0,
        OP_OPEN  = 2'd1,
        OP_CLOSE = 2'd2,
        OP_STOP  = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        MOTION_IDLE       = 2'd0,
        MOTION_OPEN       = 2'd1,
        MOTION_CLOSE_SLOW = 2'd2,
        MOTION_CLOSE_FAST = 2'd3
    } motion_t;

    typedef enum logic [2:0] {
        REASON_NONE          = 3'd0,
        REASON_STALL         = 3'd1,
        REASON_OPEN_TIMEOUT  = 3'd2,
        REASON_CLOSE_TIMEOUT = 3'd3,
        REASON_OPEN_LIMIT    = 3'd4,
        REASON_CLOSED_LIMIT  = 3'd5,
        REASON_STOP_CMD      = 3'd6
    } reason_t;

    typedef struct packed {
        logic [7:0]  fast_duty;
        logic [7:0]  slow_duty;
        logic [7:0]  min_duty;
        logic [7:0]  ramp_increment;
        logic [15:0] ramp_interval_ms;
        logic [31:0] open_timeout_ms;
        logic [31:0] close_timeout_ms;
        logic [15:0] stall_timeout_ms;
    } cfg_t;

    typedef struct packed {
        opcode_t     opcode;
        logic [31:0] now_ms;
        logic [7:0]  new_pulses;
        logic        open_limit;
        logic        closed_limit;
    } item_t;

    typedef struct packed {
        logic [7:0] duty;
        logic       dir_open;
        motion_t    motion;
        reason_t    stop_reason;
        logic       rejected;
    } result_t;

endpackage

>>> design/dmrc_cfg_regs.sv
// ----------------------------------------------------------------------------
// dmrc_cfg_regs
// configuration register file, written through a plain write port
// ----------------------------------------------------------------------------
module dmrc_cfg_regs
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_wdata,
    output dmrc_pkg::cfg_t      cfg
);

    dmrc_pkg::cfg_t cfg_reg;
    dmrc_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                dmrc_pkg::REG_FAST_DUTY:        cfg_next.fast_duty        = cfg_wdata[7:0];
                dmrc_pkg::REG_SLOW_DUTY:        cfg_next.slow_duty        = cfg_wdata[7:0];
                dmrc_pkg::REG_MIN_DUTY:         cfg_next.min_duty         = cfg_wdata[7:0];
                dmrc_pkg::REG_RAMP_INCREMENT:   cfg_next.ramp_increment   = cfg_wdata[7:0];
                dmrc_pkg::REG_RAMP_INTERVAL_MS: cfg_next.ramp_interval_ms = cfg_wdata[15:0];
                dmrc_pkg::REG_OPEN_TIMEOUT_MS:  cfg_next.open_timeout_ms  = cfg_wdata;
                dmrc_pkg::REG_CLOSE_TIMEOUT_MS: cfg_next.close_timeout_ms = cfg_wdata;
                dmrc_pkg::REG_STALL_TIMEOUT_MS: cfg_next.stall_timeout_ms = cfg_wdata[15:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fast_duty        <= dmrc_pkg::RST_FAST_DUTY;
            cfg_reg.slow_duty        <= dmrc_pkg::RST_SLOW_DUTY;
            cfg_reg.min_duty         <= dmrc_pkg::RST_MIN_DUTY;
            cfg_reg.ramp_increment   <= dmrc_pkg::RST_RAMP_INCREMENT;
            cfg_reg.ramp_interval_ms <= dmrc_pkg::RST_RAMP_INTERVAL_MS;
            cfg_reg.open_timeout_ms  <= dmrc_pkg::RST_OPEN_TIMEOUT_MS;
            cfg_reg.close_timeout_ms <= dmrc_pkg::RST_CLOSE_TIMEOUT_MS;
            cfg_reg.stall_timeout_ms <= dmrc_pkg::RST_STALL_TIMEOUT_MS;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> design/dmrc_in_reg.sv
// ----------------------------------------------------------------------------
// dmrc_in_reg
// input register; holds one item while the result side is stalled
// ----------------------------------------------------------------------------
module dmrc_in_reg
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  dmrc_pkg::item_t     item_in,
    output logic                item_valid,
    input  logic                item_take,
    output dmrc_pkg::item_t     item
);

    logic            valid_reg;
    logic            valid_next;
    dmrc_pkg::item_t item_reg;

    // the register can load when empty or when its item moves on this cycle
    assign in_stall   = valid_reg && !item_take;
    assign valid_next = in_valid ? 1'b1 : (valid_reg && !item_take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            item_reg <= item_in;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

>>> design/dmrc_seq.sv
// ----------------------------------------------------------------------------
// dmrc_seq
// motion sequencer: state registers and the single-pass update per item
// ----------------------------------------------------------------------------
module dmrc_seq
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  dmrc_pkg::item_t     item,
    input  dmrc_pkg::cfg_t      cfg,
    output dmrc_pkg::result_t   result
);

    dmrc_pkg::motion_t motion_reg, motion_next;
    logic [7:0]        cur_reg, cur_next;
    logic [7:0]        tgt_reg, tgt_next;
    logic              dir_reg, dir_next;
    logic [31:0]       step_time_reg, step_time_next;
    logic [31:0]       start_time_reg, start_time_next;
    logic [31:0]       pulse_time_reg, pulse_time_next;
    logic              pending_reg, pending_next;

    logic              opening;
    logic              pulse_hit;
    logic [31:0]       pulse_time_eff;
    logic [31:0]       since_pulse;
    logic [31:0]       since_start;
    logic [31:0]       since_step;
    logic              stall_hit;
    logic              timeout_hit;
    logic              limit_hit;
    logic              step_due;
    logic [8:0]        up_sum;
    logic [7:0]        up_val;
    logic [7:0]        down_val;
    logic [7:0]        ramp_val;
    logic [7:0]        ramp_duty;
    logic [7:0]        stepped_duty;
    dmrc_pkg::reason_t reason;
    logic              rej;

    assign opening        = (motion_reg == dmrc_pkg::MOTION_OPEN);
    assign pulse_hit      = (item.new_pulses != 8'd0) || pending_reg;
    assign pulse_time_eff = pulse_hit ? item.now_ms : pulse_time_reg;
    assign since_pulse    = item.now_ms - pulse_time_eff;
    assign since_start    = item.now_ms - start_time_reg;
    assign since_step     = item.now_ms - step_time_reg;
    assign stall_hit      = since_pulse > {16'd0, cfg.stall_timeout_ms};
    assign timeout_hit    = opening ? (since_start > cfg.open_timeout_ms)
                                    : (since_start > cfg.close_timeout_ms);
    assign limit_hit      = opening ? item.open_limit : item.closed_limit;
    assign step_due       = since_step >= {16'd0, cfg.ramp_interval_ms};

    // one ramp step toward the target, clamped at the target
    assign up_sum   = {1'b0, cur_reg} + {1'b0, cfg.ramp_increment};
    assign up_val   = (up_sum > {1'b0, tgt_reg}) ? tgt_reg : up_sum[7:0];
    assign down_val = (cfg.ramp_increment >= cur_reg) ? 8'd0 : (cur_reg - cfg.ramp_increment);
    assign ramp_val = (cur_reg < tgt_reg) ? up_val
                                          : ((down_val < tgt_reg) ? tgt_reg : down_val);
    // nonzero duty below the floor is raised to it
    assign ramp_duty = ((ramp_val != 8'd0) && (ramp_val < cfg.min_duty)) ? cfg.min_duty
                                                                        : ramp_val;
    assign stepped_duty = (step_due && (cur_reg != tgt_reg)) ? ramp_duty : cur_reg;

    always_comb
    begin
        motion_next     = motion_reg;
        cur_next        = cur_reg;
        tgt_next        = tgt_reg;
        dir_next        = dir_reg;
        step_time_next  = step_time_reg;
        start_time_next = start_time_reg;
        pulse_time_next = pulse_time_reg;
        pending_next    = pending_reg;
        reason          = dmrc_pkg::REASON_NONE;
        rej             = 1'b0;

        unique case (item.opcode)
            dmrc_pkg::OP_POLL:
            begin
                if (motion_reg != dmrc_pkg::MOTION_IDLE)
                begin
                    pulse_time_next = pulse_time_eff;
                    pending_next    = 1'b0;
                    if (stall_hit)
                        reason = dmrc_pkg::REASON_STALL;
                    else if (timeout_hit)
                        reason = opening ? dmrc_pkg::REASON_OPEN_TIMEOUT
                                         : dmrc_pkg::REASON_CLOSE_TIMEOUT;
                    else if (limit_hit)
                        reason = opening ? dmrc_pkg::REASON_OPEN_LIMIT
                                         : dmrc_pkg::REASON_CLOSED_LIMIT;

                    if (reason != dmrc_pkg::REASON_NONE)
                    begin
                        motion_next = dmrc_pkg::MOTION_IDLE;
                        cur_next    = 8'd0;
                        tgt_next    = 8'd0;
                    end
                    else
                    begin
                        if (step_due)
                            step_time_next = item.now_ms;
                        cur_next = stepped_duty;
                        // slow closing hands over to fast once slow duty is reached
                        if ((motion_reg == dmrc_pkg::MOTION_CLOSE_SLOW) &&
                            (stepped_duty >= cfg.slow_duty))
                        begin
                            tgt_next    = cfg.fast_duty;
                            motion_next = dmrc_pkg::MOTION_CLOSE_FAST;
                        end
                    end
                end
            end
            dmrc_pkg::OP_STOP:
            begin
                motion_next  = dmrc_pkg::MOTION_IDLE;
                cur_next     = 8'd0;
                tgt_next     = 8'd0;
                pending_next = 1'b0;
                reason       = dmrc_pkg::REASON_STOP_CMD;
            end
            dmrc_pkg::OP_OPEN, dmrc_pkg::OP_CLOSE:
            begin
                if (motion_reg != dmrc_pkg::MOTION_IDLE)
                begin
                    rej = 1'b1;
                    if (item.new_pulses != 8'd0)
                        pending_next = 1'b1;
                end
                else
                begin
                    pulse_time_next = item.now_ms;
                    start_time_next = item.now_ms;
                    step_time_next  = item.now_ms;
                    cur_next        = 8'd0;
                    pending_next    = 1'b0;
                    if (item.opcode == dmrc_pkg::OP_OPEN)
                    begin
                        dir_next    = 1'b1;
                        tgt_next    = cfg.fast_duty;
                        motion_next = dmrc_pkg::MOTION_OPEN;
                    end
                    else
                    begin
                        dir_next    = 1'b0;
                        tgt_next    = cfg.slow_duty;
                        motion_next = dmrc_pkg::MOTION_CLOSE_SLOW;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            motion_reg     <= dmrc_pkg::MOTION_IDLE;
            cur_reg        <= 8'd0;
            tgt_reg        <= 8'd0;
            dir_reg        <= 1'b0;
            step_time_reg  <= 32'd0;
            start_time_reg <= 32'd0;
            pulse_time_reg <= 32'd0;
            pending_reg    <= 1'b0;
        end
        else if (fire)
        begin
            motion_reg     <= motion_next;
            cur_reg        <= cur_next;
            tgt_reg        <= tgt_next;
            dir_reg        <= dir_next;
            step_time_reg  <= step_time_next;
            start_time_reg <= start_time_next;
            pulse_time_reg <= pulse_time_next;
            pending_reg    <= pending_next;
        end
    end

    assign result.duty        = cur_next;
    assign result.dir_open    = dir_next;
    assign result.motion      = motion_next;
    assign result.stop_reason = reason;
    assign result.rejected    = rej;

endmodule

>>> design/dmrc_out_reg.sv
// ----------------------------------------------------------------------------
// dmrc_out_reg
// result register toward the downstream side
// ----------------------------------------------------------------------------
module dmrc_out_reg
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  dmrc_pkg::result_t   result_in,
    output logic                can_load,
    output logic                out_valid,
    input  logic                out_stall,
    output dmrc_pkg::result_t   result
);

    logic              valid_reg;
    logic              valid_next;
    dmrc_pkg::result_t result_reg;

    assign can_load   = !valid_reg || !out_stall;
    assign valid_next = load ? 1'b1 : (valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result_in;
        end
    end

    assign out_valid = valid_reg;
    assign result    = result_reg;

endmodule

>>> design/door_motor_ramp_controller_unit.sv
// ----------------------------------------------------------------------------
// door_motor_ramp_controller_unit
// soft-start pwm door motor sequencer with stall, timeout and limit stops
// ----------------------------------------------------------------------------
// Takes one item per clock cycle while nothing stalls and gives exactly one
// result item for each, via the input register and the sequencer into the
// result register. The rate is set by the sequencer state loop, which does
// one compare-and-step pass over the motion state, duty and timers per item.
// Input and result registers both hold an item, so the input side keeps
// taking items while a result waits on out_stall, and stalls only once both
// are full. Configuration is written through cfg_we / cfg_index / cfg_wdata;
// the user must do so only while the block is idle, which is not enforced.
module door_motor_ramp_controller_unit
(
    input  logic        clk,
    input  logic        rst_n,

    // configuration write port
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wdata,

    // input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  opcode,
    input  logic [31:0] now_ms,
    input  logic [7:0]  new_pulses,
    input  logic        open_limit,
    input  logic        closed_limit,

    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  duty,
    output logic        dir_open,
    output logic [1:0]  motion,
    output logic [2:0]  stop_reason,
    output logic        rejected
);

    dmrc_pkg::cfg_t    cfg;
    dmrc_pkg::item_t   item_in;
    dmrc_pkg::item_t   item;
    dmrc_pkg::result_t seq_result;
    dmrc_pkg::result_t result;
    logic              item_valid;
    logic              can_load;
    logic              fire;

    // pack the input item fields
    assign item_in.opcode       = dmrc_pkg::opcode_t'(opcode);
    assign item_in.now_ms       = now_ms;
    assign item_in.new_pulses   = new_pulses;
    assign item_in.open_limit   = open_limit;
    assign item_in.closed_limit = closed_limit;

    // an item moves from the input register into the sequencer when the
    // result register is free or drains in the same cycle
    assign fire = item_valid && can_load;

    dmrc_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    dmrc_in_reg u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .item_in    (item_in),
        .item_valid (item_valid),
        .item_take  (fire),
        .item       (item)
    );

    // state update and result for the item in the input register
    dmrc_seq u_seq
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (item),
        .cfg    (cfg),
        .result (seq_result)
    );

    dmrc_out_reg u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (fire),
        .result_in (seq_result),
        .can_load  (can_load),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .result    (result)
    );

    // unpack the result item fields
    assign duty        = result.duty;
    assign dir_open    = result.dir_open;
    assign motion      = result.motion;
    assign stop_reason = result.stop_reason;
    assign rejected    = result.rejected;

endmodule
